>>> hdl/i2cms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared types, status codes and action codes of the transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 16;

    // Buffer positions in write requests and fetch positions are carried at this width.
    localparam int POS_W = 8;

    // Bus controller status codes.
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_TX_ADR_ACK = 8'h18;
    localparam logic [7:0] ST_TX_DAT_ACK = 8'h28;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_RX_ADR_ACK = 8'h40;
    localparam logic [7:0] ST_RX_DAT_ACK = 8'h50;
    localparam logic [7:0] ST_RX_DAT_NAK = 8'h58;
    localparam logic [7:0] NO_STATE      = 8'hF8;

    localparam logic [4:0] PTR_MAX = 5'd31;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_TX      = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5,
        ACT_RESTART = 3'd6
    } action_t;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] index;
        logic [7:0] data_byte;
        logic [4:0] msg_length;
        logic [7:0] status;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       done_res;
        logic       transfer_ok;
        logic [7:0] error_status;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } wr_req_t;

endpackage

`default_nettype wire

>>> hdl/i2cms_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer message buffer
// One write port and one registered read port, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module i2cms_buf #(
    parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire                           clk,
    input  wire i2cms_pkg::wr_req_t       wr,
    input  wire                           rd_en,
    input  wire [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.pos[AW-1:0]] <= wr.data;
        end
    end

    // A write in the same cycle reaches the read register directly.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.pos[AW-1:0] == rd_addr))
            begin
                rdata_reg <= wr.data;
            end
            else
            begin
                rdata_reg <= mem[rd_addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/i2cms_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer step logic
// Transfer state registers and the single-pass reaction to one beat.
// ----------------------------------------------------------------------------
module i2cms_seq #(
    parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      advance,
    input  wire i2cms_pkg::item_t    item,
    input  wire [7:0]                rdata,
    input  wire                      rd_hit,
    output i2cms_pkg::result_t       result,
    output i2cms_pkg::wr_req_t       wr,
    output logic [4:0]               ptr_view
);

    localparam logic [i2cms_pkg::POS_W-1:0] DEPTH_POS = i2cms_pkg::POS_W'(BUFFER_DEPTH);

    logic [4:0] ptr_reg, ptr_next;
    logic [4:0] len_reg, len_next;
    logic       ok_reg, ok_next;
    logic [7:0] err_reg, err_next;

    logic [4:0] ptr_base;
    logic [4:0] ptr_rx;
    logic [i2cms_pkg::POS_W-1:0] len_pos;
    logic [i2cms_pkg::POS_W-1:0] ptr_pos;
    logic [i2cms_pkg::POS_W-1:0] idx_pos;

    always_comb
    begin
        ptr_next = ptr_reg;
        len_next = len_reg;
        ok_next  = ok_reg;
        err_next = err_reg;
        result   = '0;
        result.action = i2cms_pkg::ACT_NONE;
        wr       = '0;
        ptr_base = ptr_reg;
        ptr_rx   = ptr_reg;
        len_pos  = {{(i2cms_pkg::POS_W-5){1'b0}}, item.msg_length};
        ptr_pos  = {{(i2cms_pkg::POS_W-5){1'b0}}, ptr_reg};
        idx_pos  = {{(i2cms_pkg::POS_W-4){1'b0}}, item.index};

        unique case (item.mode)
            i2cms_pkg::MODE_LOAD:
            begin
                wr.en   = (idx_pos < DEPTH_POS);
                wr.pos  = idx_pos;
                wr.data = item.data_byte;
            end
            i2cms_pkg::MODE_START:
            begin
                len_next = (len_pos > DEPTH_POS) ? DEPTH_POS[4:0] : item.msg_length;
                ok_next  = 1'b0;
                err_next = i2cms_pkg::NO_STATE;
                result.action = i2cms_pkg::ACT_START;
            end
            i2cms_pkg::MODE_READ:
            begin
                result.read_data = rd_hit ? rdata : 8'h00;
            end
            i2cms_pkg::MODE_EVENT:
            begin
                unique case (item.status) inside
                    i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START,
                    i2cms_pkg::ST_TX_ADR_ACK, i2cms_pkg::ST_TX_DAT_ACK:
                    begin
                        if ((item.status == i2cms_pkg::ST_START) ||
                            (item.status == i2cms_pkg::ST_REP_START))
                        begin
                            ptr_base = 5'd0;
                        end
                        ptr_next = ptr_base;
                        if (ptr_base < len_reg)
                        begin
                            result.tx_byte = rd_hit ? rdata : 8'h00;
                            ptr_next       = ptr_base + 5'd1;
                            result.action  = i2cms_pkg::ACT_TX;
                        end
                        else
                        begin
                            ok_next         = 1'b1;
                            result.action   = i2cms_pkg::ACT_STOP;
                            result.done_res = 1'b1;
                        end
                    end
                    i2cms_pkg::ST_RX_DAT_ACK, i2cms_pkg::ST_RX_ADR_ACK:
                    begin
                        if (item.status == i2cms_pkg::ST_RX_DAT_ACK)
                        begin
                            wr.en   = (ptr_pos < DEPTH_POS);
                            wr.pos  = ptr_pos;
                            wr.data = item.data_byte;
                            if (ptr_reg < i2cms_pkg::PTR_MAX)
                            begin
                                ptr_rx = ptr_reg + 5'd1;
                            end
                        end
                        ptr_next = ptr_rx;
                        // The byte still to come is NACKed when it is the last one.
                        if (({1'b0, ptr_rx} + 6'd1) < {1'b0, len_reg})
                        begin
                            result.action = i2cms_pkg::ACT_RX_ACK;
                        end
                        else
                        begin
                            result.action = i2cms_pkg::ACT_RX_NACK;
                        end
                    end
                    i2cms_pkg::ST_RX_DAT_NAK:
                    begin
                        wr.en           = (ptr_pos < DEPTH_POS);
                        wr.pos          = ptr_pos;
                        wr.data         = item.data_byte;
                        ok_next         = 1'b1;
                        result.action   = i2cms_pkg::ACT_STOP;
                        result.done_res = 1'b1;
                    end
                    i2cms_pkg::ST_ARB_LOST:
                    begin
                        result.action = i2cms_pkg::ACT_RESTART;
                    end
                    default:
                    begin
                        err_next        = item.status;
                        result.action   = i2cms_pkg::ACT_NONE;
                        result.done_res = 1'b1;
                    end
                endcase
            end
            default:
            begin
                result.action = i2cms_pkg::ACT_NONE;
            end
        endcase

        result.transfer_ok  = ok_next;
        result.error_status = err_next;

        if (!advance)
        begin
            wr.en = 1'b0;
        end
    end

    // Pointer as the next beat will see it.
    assign ptr_view = advance ? ptr_next : ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= 5'd0;
            len_reg <= 5'd0;
            ok_reg  <= 1'b0;
            err_reg <= i2cms_pkg::NO_STATE;
        end
        else if (advance)
        begin
            ptr_reg <= ptr_next;
            len_reg <= len_next;
            ok_reg  <= ok_next;
            err_reg <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/i2c_master_transfer_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transfer sequencer core
// Buffers a message, sequences an I2C master transfer from bus status codes.
// ----------------------------------------------------------------------------
// One beat is accepted every clock cycle while the output is not stalled, and each
// beat gives exactly one result: the beat is captured in an input register together
// with the buffer byte it needs (the buffer read port is registered at acceptance),
// the step logic works on it in one pass and the answer lands in the result
// register. While a result waits to be taken, one more beat is accepted into an
// empty input register, and the input side then stalls until the result leaves.
// The message buffer needs no clearing after reset, so the block is ready as
// soon as reset is released.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core #(
    parameter int BUFFER_DEPTH = i2cms_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // index[3:0], data_byte[11:4], msg_length[16:12], status[24:17], zero fill
    input  wire  [31:0] s_tdata,
    // mode[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // action[2:0], tx_byte[10:3], read_data[18:11], done_res[19],
    // transfer_ok[20], error_status[28:21], zero fill
    output logic [31:0] m_tdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [i2cms_pkg::POS_W-1:0] DEPTH_POS = i2cms_pkg::POS_W'(BUFFER_DEPTH);

    i2cms_pkg::item_t   in_item;
    i2cms_pkg::item_t   s0_item_reg;
    logic               s0_valid_reg;
    logic               s0_hit_reg;
    i2cms_pkg::result_t res_reg;
    logic               m_valid_reg;

    i2cms_pkg::result_t step_res;
    i2cms_pkg::wr_req_t wr;
    logic [7:0]         rdata;
    logic [4:0]         ptr_view;

    logic                        out_load;
    logic                        advance;
    logic                        s_accept;
    logic [i2cms_pkg::POS_W-1:0] rd_pos;
    logic                        rd_hit;

    assign in_item.mode       = i2cms_pkg::mode_t'(s_tuser);
    assign in_item.index      = s_tdata[3:0];
    assign in_item.data_byte  = s_tdata[11:4];
    assign in_item.msg_length = s_tdata[16:12];
    assign in_item.status     = s_tdata[24:17];

    assign out_load = !m_valid_reg || m_tready;
    assign advance  = s0_valid_reg && out_load;
    assign s_tready = !s0_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    // Buffer position the incoming beat will fetch.
    always_comb
    begin
        if ((in_item.mode == i2cms_pkg::MODE_EVENT) &&
            ((in_item.status == i2cms_pkg::ST_START) ||
             (in_item.status == i2cms_pkg::ST_REP_START)))
        begin
            rd_pos = '0;
        end
        else if (in_item.mode == i2cms_pkg::MODE_EVENT)
        begin
            rd_pos = {{(i2cms_pkg::POS_W-5){1'b0}}, ptr_view};
        end
        else
        begin
            rd_pos = {{(i2cms_pkg::POS_W-4){1'b0}}, in_item.index};
        end
    end

    assign rd_hit = (rd_pos < DEPTH_POS);

    i2cms_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (s_accept),
        .rd_addr (rd_pos[AW-1:0]),
        .rdata   (rdata)
    );

    i2cms_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (s0_item_reg),
        .rdata    (rdata),
        .rd_hit   (s0_hit_reg),
        .result   (step_res),
        .wr       (wr),
        .ptr_view (ptr_view)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s0_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                m_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s0_item_reg <= in_item;
            s0_hit_reg  <= rd_hit;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.error_status, res_reg.transfer_ok,
                       res_reg.done_res, res_reg.read_data, res_reg.tx_byte,
                       res_reg.action};

    // A STOP always finishes the transfer.
    a_stop_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (res_reg.action == i2cms_pkg::ACT_STOP)) |-> res_reg.done_res)
        else $error("STOP result without done flag");

    // Only a STOP or an error ends a transfer.
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && res_reg.done_res) |->
            ((res_reg.action == i2cms_pkg::ACT_STOP) ||
             (res_reg.action == i2cms_pkg::ACT_NONE)))
        else $error("done flag on a non-terminal action");

    // The transmit byte is driven only for a transmit action.
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (res_reg.action != i2cms_pkg::ACT_TX)) |-> (res_reg.tx_byte == 8'h00))
        else $error("transmit byte set without transmit action");

    // A held beat with a stalled result keeps the buffer untouched.
    a_hold_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && m_valid_reg && !m_tready) |-> (!wr.en && !s_tready))
        else $error("buffer written or beat accepted while stalled");

endmodule

`default_nettype wire

>>> bench/tb_i2c_master_transfer_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer core testbench
// Sends load, start, bus event and read beats, with random gaps and stalls on
// both streams. A behavioral copy of the sequencer predicts every result, and
// each result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer_core;

    import i2cms_pkg::*;

    localparam int BUF_DEPTH = DEFAULT_BUFFER_DEPTH;
    localparam int RANDOM_BEATS = 1050;

    typedef struct {
        mode_t      mode;
        logic [3:0] index;
        logic [7:0] data_byte;
        logic [4:0] msg_length;
        logic [7:0] status;
        bit         drain;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    i2c_master_transfer_sequencer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    beat_t   beats_to_send[$];
    result_t results_due[$];
    int      n_items;
    int      n_acc = 0;
    int      n_ret = 0;
    bit      failed = 1'b0;

    // Mirror of the sequencer state.
    logic [7:0] mirror_buf [0:BUF_DEPTH-1];
    logic [4:0] mirror_ptr;
    logic [4:0] mirror_len;
    logic       mirror_ok;
    logic [7:0] mirror_err;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void buf_put(input logic [4:0] pos, input logic [7:0] value);
        if (pos < BUF_DEPTH)
            mirror_buf[pos] = value;
    endfunction

    function automatic logic [7:0] buf_get(input logic [4:0] pos);
        if (pos < BUF_DEPTH)
            return mirror_buf[pos];
        return 8'h00;
    endfunction

    function automatic result_t sequencer_step(input beat_t b);
        result_t r;
        r = '0;
        r.action = ACT_NONE;
        case (b.mode)
            MODE_LOAD: buf_put({1'b0, b.index}, b.data_byte);
            MODE_START:
            begin
                mirror_len = (b.msg_length > BUF_DEPTH) ? 5'(BUF_DEPTH) : b.msg_length;
                mirror_ok  = 1'b0;
                mirror_err = NO_STATE;
                r.action   = ACT_START;
            end
            MODE_READ: r.read_data = buf_get({1'b0, b.index});
            default:
            begin
                case (b.status)
                    ST_START, ST_REP_START, ST_TX_ADR_ACK, ST_TX_DAT_ACK:
                    begin
                        if (b.status == ST_START || b.status == ST_REP_START)
                            mirror_ptr = '0;
                        if (mirror_ptr < mirror_len)
                        begin
                            r.tx_byte  = buf_get(mirror_ptr);
                            mirror_ptr = mirror_ptr + 5'd1;
                            r.action   = ACT_TX;
                        end
                        else
                        begin
                            mirror_ok  = 1'b1;
                            r.action   = ACT_STOP;
                            r.done_res = 1'b1;
                        end
                    end
                    ST_RX_DAT_ACK, ST_RX_ADR_ACK:
                    begin
                        if (b.status == ST_RX_DAT_ACK)
                        begin
                            buf_put(mirror_ptr, b.data_byte);
                            if (mirror_ptr < PTR_MAX)
                                mirror_ptr = mirror_ptr + 5'd1;
                        end
                        // The byte that will be the last one gets a NACK.
                        r.action = (int'(mirror_ptr) + 1 < int'(mirror_len)) ?
                                   ACT_RX_ACK : ACT_RX_NACK;
                    end
                    ST_RX_DAT_NAK:
                    begin
                        buf_put(mirror_ptr, b.data_byte);
                        mirror_ok  = 1'b1;
                        r.action   = ACT_STOP;
                        r.done_res = 1'b1;
                    end
                    ST_ARB_LOST: r.action = ACT_RESTART;
                    default:
                    begin
                        mirror_err = b.status;
                        r.done_res = 1'b1;
                    end
                endcase
            end
        endcase
        r.transfer_ok  = mirror_ok;
        r.error_status = mirror_err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic void queue_beat(input mode_t m, input logic [3:0] idx,
                                       input logic [7:0] d, input logic [4:0] len,
                                       input logic [7:0] st, input bit drain);
        beat_t b;
        b.mode       = m;
        b.index      = idx;
        b.data_byte  = d;
        b.msg_length = len;
        b.status     = st;
        b.drain      = drain;
        beats_to_send.push_back(b);
    endfunction

    // Fields that an operation does not use are filled at random.
    function automatic void queue_event(input logic [7:0] st, input logic [7:0] d);
        queue_beat(MODE_EVENT, 4'($urandom), d, 5'($urandom), st, 1'b0);
    endfunction

    function automatic void queue_start(input logic [4:0] len, input bit drain);
        queue_beat(MODE_START, 4'($urandom), 8'($urandom), len, 8'($urandom), drain);
    endfunction

    function automatic void queue_read(input logic [3:0] idx);
        queue_beat(MODE_READ, idx, 8'($urandom), 5'($urandom), 8'($urandom), 1'b0);
    endfunction

    function automatic logic [4:0] pick_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 5'd0;
        if (sel == 1)
            return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 16));
    endfunction

    function automatic logic [7:0] some_status();
        case ($urandom_range(0, 13))
            0:  return ST_START;
            1:  return ST_REP_START;
            2:  return ST_TX_ADR_ACK;
            3:  return ST_TX_DAT_ACK;
            4:  return ST_ARB_LOST;
            5:  return ST_RX_ADR_ACK;
            6:  return ST_RX_DAT_ACK;
            7:  return ST_RX_DAT_NAK;
            8:  return NO_STATE;
            9:  return 8'h00;
            10: return 8'h20;
            11: return 8'h48;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void queue_write_transfer();
        logic [4:0] len;
        int         n;
        int         i;
        repeat ($urandom_range(0, 3))
            queue_beat(MODE_LOAD, 4'($urandom), 8'($urandom), 5'($urandom),
                       8'($urandom), 1'b0);
        len = pick_len();
        queue_start(len, $urandom_range(0, 19) == 0);
        queue_event(ST_START, 8'($urandom));
        n = (len > BUF_DEPTH) ? BUF_DEPTH : len;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                queue_event(ST_ARB_LOST, 8'($urandom));
                queue_event(ST_REP_START, 8'($urandom));
            end
            if ($urandom_range(0, 39) == 0)
            begin
                queue_event(some_status(), 8'($urandom));
                break;
            end
            queue_event((i == 0) ? ST_TX_ADR_ACK : ST_TX_DAT_ACK, 8'($urandom));
        end
    endfunction

    function automatic void queue_read_transfer();
        logic [4:0] len;
        int         n;
        int         k;
        len = pick_len();
        n = (len > BUF_DEPTH) ? BUF_DEPTH : len;
        queue_start(len, $urandom_range(0, 19) == 0);
        queue_event(ST_START, 8'($urandom));
        queue_event(ST_RX_ADR_ACK, 8'($urandom));
        // Now and then run far past the buffer so the pointer saturates.
        if ($urandom_range(0, 9) == 0)
            k = $urandom_range(14, 36);
        else
            k = (n >= 2) ? n - 2 : 0;
        repeat (k)
            queue_event(ST_RX_DAT_ACK, 8'($urandom));
        if ($urandom_range(0, 29) == 0)
            queue_event(some_status(), 8'($urandom));
        queue_event(ST_RX_DAT_NAK, 8'($urandom));
        repeat ($urandom_range(0, 3))
            queue_read(4'($urandom));
    endfunction

    function automatic void queue_noise();
        queue_beat(mode_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom),
                   5'($urandom), ($urandom_range(0, 1) == 0) ? some_status() : 8'($urandom),
                   1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued beats with random gaps.
    // ------------------------------------------------------------------
    beat_t cur_beat;
    bit    next_valid;
    int    gap_left = 0;
    bit    send_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                results_due.push_back(sequencer_step(cur_beat));
                n_acc <= n_acc + 1;
                if ($urandom_range(0, 49) == 0)
                    send_calm = ~send_calm;
                gap_left = send_calm ? 0 : $urandom_range(0, 17);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (beats_to_send.size() != 0 &&
                         (!beats_to_send[0].drain || results_due.size() == 0))
                begin
                    cur_beat = beats_to_send.pop_front();
                    s_tdata  <= {7'd0, cur_beat.status, cur_beat.msg_length,
                                 cur_beat.data_byte, cur_beat.index};
                    s_tuser  <= cur_beat.mode;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and result checking.
    // ------------------------------------------------------------------
    result_t want;
    bit      next_ready;
    int      stall_left = 0;
    bit      recv_calm = 1'b0;

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            next_ready = m_tready;
            if (m_tvalid && m_tready)
            begin
                n_ret <= n_ret + 1;
                if (results_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    failed = 1'b1;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("action", 8'(want.action), 8'(m_tdata[2:0]));
                    check_field("tx_byte", want.tx_byte, m_tdata[10:3]);
                    check_field("read_data", want.read_data, m_tdata[18:11]);
                    check_field("done_res", 8'(want.done_res), 8'(m_tdata[19]));
                    check_field("transfer_ok", 8'(want.transfer_ok), 8'(m_tdata[20]));
                    check_field("error_status", want.error_status, m_tdata[28:21]);
                end
                if ($urandom_range(0, 49) == 0)
                    recv_calm = ~recv_calm;
                stall_left = recv_calm ? 0 : $urandom_range(0, 17);
                next_ready = (stall_left == 0);
            end
            else if (!m_tready)
            begin
                if (stall_left > 0)
                    stall_left--;
                next_ready = (stall_left == 0);
            end
            m_tready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial
    begin
        int sel;
        mirror_ptr = '0;
        mirror_len = '0;
        mirror_ok  = 1'b0;
        mirror_err = NO_STATE;

        // A bus event before any transfer was ever started.
        queue_event(ST_TX_DAT_ACK, 8'($urandom));
        // Fill the whole buffer first so no later fetch hits an unwritten entry.
        for (int i = 0; i < BUF_DEPTH; i++)
            queue_beat(MODE_LOAD, 4'(i), (i == 1) ? 8'h00 : (i == 15) ? 8'hFF : 8'($urandom),
                       5'($urandom), 8'($urandom), 1'b0);
        queue_read(4'd0);
        queue_read(4'd15);
        // Zero-length write: STOP right after START.
        queue_start(5'd0, 1'b0);
        queue_event(ST_START, 8'($urandom));
        // Oversized length saturates to the buffer depth.
        queue_start(5'd31, 1'b0);
        queue_event(ST_REP_START, 8'($urandom));
        queue_event(ST_ARB_LOST, 8'($urandom));
        // Bus error and the no-state code are both latched as errors.
        queue_event(8'h00, 8'($urandom));
        queue_event(NO_STATE, 8'($urandom));
        // Zero-length read: the first byte is NACKed.
        queue_start(5'd0, 1'b0);
        queue_event(ST_RX_ADR_ACK, 8'($urandom));
        queue_event(ST_RX_DAT_NAK, 8'hFF);
        queue_read(4'd1);

        queue_start(pick_len(), 1'b1);
        while (beats_to_send.size() < RANDOM_BEATS)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 8)
                queue_write_transfer();
            else if (sel < 15)
                queue_read_transfer();
            else if (sel < 17)
                queue_read(4'($urandom));
            else
                queue_noise();
        end
        n_items = beats_to_send.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (n_acc != n_items)
            @(negedge clk);
        while (n_ret != n_items)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hdl/i2cms_pkg.sv
hdl/i2cms_buf.sv
hdl/i2cms_seq.sv
hdl/i2c_master_transfer_sequencer_core.sv
bench/tb_i2c_master_transfer_sequencer_core.sv
